// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers, used by ema_trend_signal_core to check its own behavior.
// Both macros sample on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define ETS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ETS_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ets_pkg.sv =====
package ets_pkg;

    // Field widths of the tick and result beats.
    localparam int PRICE_W     = 32;
    localparam int VOL_W       = 24;
    localparam int ALPHA_W     = 16;
    localparam int COUNT_W     = 8;
    localparam int SIG_W       = 2;
    localparam int VAR_W       = 2 * PRICE_W;
    localparam int MUL_W       = 32;
    localparam int PROD_W      = 2 * MUL_W;

    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 96;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    localparam int ALPHA_FRAC_BITS_DEF = 16;

    // Register values after reset, and the ceiling of the tick count.
    localparam logic [ALPHA_W-1:0] ALPHA_RESET  = 16'd3277;
    localparam logic [VOL_W-1:0]   LIMIT_RESET  = 24'd19661;
    localparam logic [COUNT_W-1:0] WARMUP_RESET = 8'd10;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALPHA  = 2'd0,
        REG_LIMIT  = 2'd1,
        REG_WARMUP = 2'd2
    } cfg_reg_t;

    typedef enum logic [SIG_W-1:0] {
        SIG_HOLD = 2'd0,
        SIG_BUY  = 2'd1,
        SIG_SELL = 2'd2
    } signal_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MUL  = 3'b010,
        ST_ROOT = 3'b100
    } state_t;

    // What the accumulator does with the product registered in the previous cycle.
    typedef enum logic [1:0] {
        ACC_HOLD   = 2'd0,
        ACC_FIRST  = 2'd1,
        ACC_ADD    = 2'd2,
        ACC_ADD_HI = 2'd3
    } acc_op_t;

    typedef struct packed {
        logic [MUL_W-1:0] x;
        logic [MUL_W-1:0] w;
        acc_op_t          op;
    } mac_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } root_stat_t;

endpackage

// ===== hw/rtl/ets_mac.sv =====
// Shared multiply-accumulate unit. The product is registered, and the
// accumulator folds in the product of the previous cycle, so a blend
// result appears in acc_reg once its last product has passed prod_reg.
module ets_mac #(
    parameter int ALPHA_FRAC_BITS = ets_pkg::ALPHA_FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  ets_pkg::mac_req_t            req,
    output logic [ets_pkg::PROD_W-1:0]   prod,
    output logic [ets_pkg::PROD_W-1:0]   blend
);

    localparam int ACC_W = ets_pkg::PROD_W + ALPHA_FRAC_BITS + 1;
    localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (ALPHA_FRAC_BITS - 1);

    logic [ets_pkg::PROD_W-1:0] prod_reg;
    logic [ets_pkg::PROD_W-1:0] prod_next;
    logic [ACC_W-1:0]           acc_reg;
    logic [ACC_W-1:0]           acc_next;

    assign prod_next = ets_pkg::PROD_W'(req.x) * ets_pkg::PROD_W'(req.w);

    always_comb
    begin
        unique case (req.op)
            ets_pkg::ACC_HOLD:   acc_next = acc_reg;
            ets_pkg::ACC_FIRST:  acc_next = HALF + ACC_W'(prod_reg);
            ets_pkg::ACC_ADD:    acc_next = acc_reg + ACC_W'(prod_reg);
            ets_pkg::ACC_ADD_HI: acc_next = acc_reg + (ACC_W'(prod_reg) << ets_pkg::MUL_W);
            default:             acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign prod  = prod_reg;
    assign blend = acc_reg[ALPHA_FRAC_BITS +: ets_pkg::PROD_W];

endmodule

// ===== hw/rtl/ets_isqrt.sv =====
// Restoring integer square root, one result bit per cycle.
module ets_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ets_pkg::VAR_W-1:0]     radicand,
    output ets_pkg::root_stat_t           stat,
    output logic [ets_pkg::PRICE_W-1:0]   root
);

    localparam int ROOT_W = ets_pkg::VAR_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int ITER_W = $clog2(ROOT_W);

    logic [ets_pkg::VAR_W-1:0] rad_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [ROOT_W-1:0]         root_reg;
    logic [ITER_W-1:0]         iter_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [REM_W+1:0]          rem_shift;
    logic [REM_W+1:0]          trial;
    logic                      fits;

    assign rem_shift = {rem_reg, rad_reg[ets_pkg::VAR_W-1 -: 2]};
    assign trial     = (REM_W + 2)'({root_reg, 2'b01});
    assign fits      = rem_shift >= trial;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            if (fits)
            begin
                rem_reg  <= REM_W'(rem_shift - trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= REM_W'(rem_shift);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else if (busy_reg)
        begin
            iter_reg <= iter_reg + ITER_W'(1);
            if (iter_reg == '1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = ets_pkg::PRICE_W'(root_reg);

endmodule

// ===== hw/rtl/ema_trend_signal_core.sv =====
// Trend signal from exponential moving averages of price and volatility.
// Ticks arrive on the s_axis channel, one beat each (price and volatility);
// every tick yields exactly one result beat on m_axis with the decision
// (hold, buy or sell), the updated averages and the price deviation.
// Configuration goes through the cfg channel, which is always ready:
// index 0 sets the smoothing weight, 1 the volatility limit, 2 the warm-up
// count. Write it only while no tick is in flight.
// A tick's result beat is presented in the same cycle in which s_axis_tready
// returns high, so the block takes no new tick before the previous one is
// done. The very first tick after reset skips the shared multiplier and only
// takes the root of zero. Otherwise the result waits on the square root of
// the moving variance, one root bit per cycle, which starts once the variance
// blend, within the eleven multiplier steps, is complete; later steps overlap it.
// While a tick is processed s_axis_tready is low. The result sits in an
// output register, so a new tick is taken while the previous result still
// waits; if the receiver stalls long enough for the next result to be
// done too, the block holds that result internally until the register frees.
// Reset clears the averages, the variance and the tick count and restores
// the register defaults; no result is pending after reset.
`include "assert_macros.svh"

module ema_trend_signal_core #(
    parameter int ALPHA_FRAC_BITS = ets_pkg::ALPHA_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tick_price [31:0], tick_volatility [55:32]
    input  logic [ets_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // trade_signal [1:0], average_price [33:2], average_volatility [57:34],
    // price_deviation [89:58], zero [95:90]
    output logic [ets_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ets_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ets_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int PRICE_W = ets_pkg::PRICE_W;
    localparam int VOL_W   = ets_pkg::VOL_W;
    localparam int VAR_W   = ets_pkg::VAR_W;
    localparam int MUL_W   = ets_pkg::MUL_W;
    localparam int COUNT_W = ets_pkg::COUNT_W;
    localparam int AW      = ALPHA_FRAC_BITS + 1;
    localparam int CMP_W   = ets_pkg::ALPHA_W + AW;
    localparam int OUT_PAD_W = ets_pkg::OUT_DATA_W
                             - (ets_pkg::SIG_W + 2 * PRICE_W + VOL_W);
    localparam logic [AW-1:0] WEIGHT_ONE = AW'(1) << ALPHA_FRAC_BITS;

    // Sequencer steps. The steps up to STEP_VOL_A each issue one multiply; the
    // accumulator folds in the product of the step before where a step asks it to.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_SQUARE   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_VAR_LO_B = 4'd1;
    localparam logic [STEP_W-1:0] STEP_VAR_LO_A = 4'd2;
    localparam logic [STEP_W-1:0] STEP_VAR_HI_B = 4'd3;
    localparam logic [STEP_W-1:0] STEP_VAR_HI_A = 4'd4;
    localparam logic [STEP_W-1:0] STEP_PRICE_B  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_PRICE_A  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_VOL_B    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_VOL_A    = 4'd8;
    localparam logic [STEP_W-1:0] STEP_VOL_SUM  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_VOL_DONE = 4'd10;

    ets_pkg::state_t               state_reg;
    ets_pkg::state_t               state_next;
    logic [STEP_W-1:0]             step_reg;
    logic [STEP_W-1:0]             step_next;

    logic [PRICE_W-1:0]            price_reg;
    logic [VOL_W-1:0]              vol_reg;
    logic [VAR_W-1:0]              sq_reg;

    logic [PRICE_W-1:0]            avg_p_reg;
    logic [VOL_W-1:0]              avg_v_reg;
    logic [VAR_W-1:0]              var_reg;
    logic [COUNT_W-1:0]            ticks_reg;
    logic [COUNT_W-1:0]            ticks_next;

    logic [ets_pkg::ALPHA_W-1:0]   alpha_reg;
    logic [VOL_W-1:0]              limit_reg;
    logic [COUNT_W-1:0]            warmup_reg;

    logic                          out_valid_reg;
    logic [ets_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic                          in_accept;
    logic                          first_tick;
    logic                          finish;
    logic [AW-1:0]                 weight_a;
    logic [AW-1:0]                 weight_b;
    logic [PRICE_W-1:0]            mag;
    ets_pkg::signal_t              signal;

    ets_pkg::mac_req_t             mac_req;
    logic [ets_pkg::PROD_W-1:0]    mac_prod;
    logic [ets_pkg::PROD_W-1:0]    mac_blend;

    logic                          root_start;
    logic [VAR_W-1:0]              root_radicand;
    ets_pkg::root_stat_t           root_stat;
    logic [PRICE_W-1:0]            root_value;

    assign s_axis_tready = (state_reg == ets_pkg::ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign first_tick    = (ticks_reg == '0);
    assign cfg_ready     = 1'b1;

    // The weight of the new sample is limited to one.
    always_comb
    begin
        if (CMP_W'(alpha_reg) > CMP_W'(WEIGHT_ONE))
        begin
            weight_a = WEIGHT_ONE;
        end
        else
        begin
            weight_a = AW'(alpha_reg);
        end
        weight_b = WEIGHT_ONE - weight_a;
    end

    // Distance of the price from the average before this tick updates it.
    assign mag = (price_reg >= avg_p_reg) ? (price_reg - avg_p_reg)
                                          : (avg_p_reg - price_reg);

    // Operand selection for the shared multiplier. Each blend sums
    // weight_b times the old value and weight_a times the new sample; the
    // variance is handled as two 32-bit halves.
    always_comb
    begin
        mac_req.x  = '0;
        mac_req.w  = '0;
        mac_req.op = ets_pkg::ACC_HOLD;
        if (state_reg == ets_pkg::ST_MUL)
        begin
            unique case (step_reg)
                STEP_SQUARE:
                begin
                    mac_req.x = MUL_W'(mag);
                    mac_req.w = MUL_W'(mag);
                end
                STEP_VAR_LO_B:
                begin
                    mac_req.x = var_reg[MUL_W-1:0];
                    mac_req.w = MUL_W'(weight_b);
                end
                STEP_VAR_LO_A:
                begin
                    mac_req.x  = sq_reg[MUL_W-1:0];
                    mac_req.w  = MUL_W'(weight_a);
                    mac_req.op = ets_pkg::ACC_FIRST;
                end
                STEP_VAR_HI_B:
                begin
                    mac_req.x  = var_reg[VAR_W-1:MUL_W];
                    mac_req.w  = MUL_W'(weight_b);
                    mac_req.op = ets_pkg::ACC_ADD;
                end
                STEP_VAR_HI_A:
                begin
                    mac_req.x  = sq_reg[VAR_W-1:MUL_W];
                    mac_req.w  = MUL_W'(weight_a);
                    mac_req.op = ets_pkg::ACC_ADD_HI;
                end
                STEP_PRICE_B:
                begin
                    mac_req.x  = MUL_W'(avg_p_reg);
                    mac_req.w  = MUL_W'(weight_b);
                    mac_req.op = ets_pkg::ACC_ADD_HI;
                end
                STEP_PRICE_A:
                begin
                    mac_req.x  = MUL_W'(price_reg);
                    mac_req.w  = MUL_W'(weight_a);
                    mac_req.op = ets_pkg::ACC_FIRST;
                end
                STEP_VOL_B:
                begin
                    mac_req.x  = MUL_W'(avg_v_reg);
                    mac_req.w  = MUL_W'(weight_b);
                    mac_req.op = ets_pkg::ACC_ADD;
                end
                STEP_VOL_A:
                begin
                    mac_req.x  = MUL_W'(vol_reg);
                    mac_req.w  = MUL_W'(weight_a);
                    mac_req.op = ets_pkg::ACC_FIRST;
                end
                STEP_VOL_SUM:
                begin
                    mac_req.op = ets_pkg::ACC_ADD;
                end
                default:
                begin
                end
            endcase
        end
    end

    ets_mac #(
        .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
    ) u_mac (
        .clk   (clk),
        .req   (mac_req),
        .prod  (mac_prod),
        .blend (mac_blend)
    );

    // The root starts on zero for the first tick and on the new variance
    // as soon as the variance blend is complete otherwise.
    assign root_start    = (in_accept && first_tick)
                        || (state_reg == ets_pkg::ST_MUL && step_reg == STEP_PRICE_A);
    assign root_radicand = (state_reg == ets_pkg::ST_MUL) ? mac_blend : '0;

    ets_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (root_radicand),
        .stat     (root_stat),
        .root     (root_value)
    );

    assign finish = (state_reg == ets_pkg::ST_ROOT) && root_stat.done
                 && (!out_valid_reg || m_axis_tready);

    assign ticks_next = (ticks_reg == ets_pkg::COUNT_MAX) ? ticks_reg
                                                          : ticks_reg + COUNT_W'(1);

    // Decision from the updated averages and this tick's price. A price equal
    // to the average holds.
    always_comb
    begin
        signal = ets_pkg::SIG_HOLD;
        if (ticks_next >= warmup_reg)
        begin
            priority if (price_reg > avg_p_reg && avg_v_reg < limit_reg)
            begin
                signal = ets_pkg::SIG_BUY;
            end
            else if (price_reg < avg_p_reg)
            begin
                signal = ets_pkg::SIG_SELL;
            end
            else
            begin
                signal = ets_pkg::SIG_HOLD;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ets_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    step_next = STEP_SQUARE;
                    if (first_tick)
                    begin
                        state_next = ets_pkg::ST_ROOT;
                    end
                    else
                    begin
                        state_next = ets_pkg::ST_MUL;
                    end
                end
            end
            ets_pkg::ST_MUL:
            begin
                if (step_reg == STEP_VOL_DONE)
                begin
                    state_next = ets_pkg::ST_ROOT;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ets_pkg::ST_ROOT:
            begin
                if (finish)
                begin
                    state_next = ets_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ets_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ets_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Tick payload, the registered square and the result beat.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            price_reg <= s_axis_tdata[PRICE_W-1:0];
            vol_reg   <= s_axis_tdata[PRICE_W +: VOL_W];
        end
        if (state_reg == ets_pkg::ST_MUL && step_reg == STEP_VAR_LO_B)
        begin
            sq_reg <= mac_prod;
        end
        if (finish)
        begin
            out_data_reg <= {OUT_PAD_W'(0), root_value, avg_v_reg, avg_p_reg, signal};
        end
    end

    // Averages, variance and tick count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_p_reg <= '0;
            avg_v_reg <= '0;
            var_reg   <= '0;
            ticks_reg <= '0;
        end
        else
        begin
            if (in_accept && first_tick)
            begin
                avg_p_reg <= s_axis_tdata[PRICE_W-1:0];
                avg_v_reg <= s_axis_tdata[PRICE_W +: VOL_W];
                var_reg   <= '0;
            end
            if (state_reg == ets_pkg::ST_MUL)
            begin
                if (step_reg == STEP_PRICE_A)
                begin
                    var_reg <= mac_blend;
                end
                if (step_reg == STEP_VOL_A)
                begin
                    avg_p_reg <= mac_blend[PRICE_W-1:0];
                end
                if (step_reg == STEP_VOL_DONE)
                begin
                    avg_v_reg <= mac_blend[VOL_W-1:0];
                end
            end
            if (finish)
            begin
                ticks_reg <= ticks_next;
            end
        end
    end

    // Configuration registers; an index outside the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg  <= ets_pkg::ALPHA_RESET;
            limit_reg  <= ets_pkg::LIMIT_RESET;
            warmup_reg <= ets_pkg::WARMUP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ets_pkg::REG_ALPHA:  alpha_reg  <= cfg_data[ets_pkg::ALPHA_W-1:0];
                ets_pkg::REG_LIMIT:  limit_reg  <= cfg_data[VOL_W-1:0];
                ets_pkg::REG_WARMUP: warmup_reg <= cfg_data[COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Output register: filled when a tick finishes, freed when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // A tick is never taken back to back with another one.
    `ETS_ASSERT(a_one_tick_in_flight, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "tick accepted while busy")
    // The root unit is quiet whenever the sequencer is idle.
    `ETS_ASSERT_ALWAYS(a_root_idle, state_reg == ets_pkg::ST_IDLE |-> !root_stat.busy, "root busy in idle")
    // A result only appears once its root has been computed.
    `ETS_ASSERT(a_result_after_root, $rose(m_axis_tvalid) |-> $past(root_stat.done), "result before root")
    // Once nonzero, the tick count never drops back to zero until reset.
    `ETS_ASSERT(a_count_kept, ticks_reg != '0 |=> ticks_reg != '0, "tick count dropped to zero")

endmodule

// ===== tb/ema_trend_signal_core_test.sv =====
// Mirror of the block's moving averages, variance and tick count, plus the
// queue of result beats that the accepted ticks are due to produce.
class trend_book;

    localparam int FRAC = ets_pkg::ALPHA_FRAC_BITS_DEF;
    localparam logic [16:0] WEIGHT_ONE = 17'd1 << FRAC;

    typedef struct packed {
        ets_pkg::signal_t  sig;
        logic [31:0]       avg_price;
        logic [23:0]       avg_vol;
        logic [31:0]       deviation;
    } trend_result_t;

    logic [15:0]     alpha;
    logic [23:0]     vol_limit;
    logic [7:0]      warmup;
    logic [31:0]     price_avg;
    logic [23:0]     vol_avg;
    logic [63:0]     variance;
    logic [7:0]      ticks;
    trend_result_t   due_results[$];
    int              failures;

    function new();
        alpha     = ets_pkg::ALPHA_RESET;
        vol_limit = ets_pkg::LIMIT_RESET;
        warmup    = ets_pkg::WARMUP_RESET;
        price_avg = '0;
        vol_avg   = '0;
        variance  = '0;
        ticks     = '0;
        failures  = 0;
    endfunction

    function void write_reg(logic [1:0] index, logic [23:0] data);
        case (index)
            ets_pkg::REG_ALPHA:  alpha = data[15:0];
            ets_pkg::REG_LIMIT:  vol_limit = data;
            ets_pkg::REG_WARMUP: warmup = data[7:0];
            default: ;
        endcase
    endfunction

    // Exact weighted blend of a new sample into an old value, rounded half up.
    function logic [63:0] smooth(logic [63:0] sample, logic [63:0] old);
        logic [16:0] weight_new;
        logic [16:0] weight_old;
        logic [95:0] acc;
        weight_new = (17'(alpha) > WEIGHT_ONE) ? WEIGHT_ONE : 17'(alpha);
        weight_old = WEIGHT_ONE - weight_new;
        acc = 96'(weight_new) * 96'(sample) + 96'(weight_old) * 96'(old)
            + (96'd1 << (FRAC - 1));
        acc = acc >> FRAC;
        return acc[63:0];
    endfunction

    function logic [31:0] floor_root(logic [63:0] n);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int i = 31; i >= 0; i--)
        begin
            trial = root | (32'd1 << i);
            if (64'(trial) * 64'(trial) <= n)
                root = trial;
        end
        return root;
    endfunction

    function void note_tick(logic [31:0] price, logic [23:0] vol);
        logic [31:0]   gap;
        logic [63:0]   blended;
        trend_result_t r;
        if (ticks == '0)
        begin
            price_avg = price;
            vol_avg   = vol;
            variance  = '0;
        end
        else
        begin
            gap = (price >= price_avg) ? price - price_avg : price_avg - price;
            blended   = smooth(64'(price), 64'(price_avg));
            price_avg = blended[31:0];
            blended   = smooth(64'(vol), 64'(vol_avg));
            vol_avg   = blended[23:0];
            variance  = smooth(64'(gap) * 64'(gap), variance);
        end
        if (ticks != ets_pkg::COUNT_MAX)
            ticks++;

        r.sig = ets_pkg::SIG_HOLD;
        if (ticks >= warmup)
        begin
            if (price > price_avg && vol_avg < vol_limit)
                r.sig = ets_pkg::SIG_BUY;
            else if (price < price_avg)
                r.sig = ets_pkg::SIG_SELL;
        end
        r.avg_price = price_avg;
        r.avg_vol   = vol_avg;
        r.deviation = floor_root(variance);
        due_results.push_back(r);
    endfunction

    function void compare_field(string what, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endfunction

    function void check_result(logic [95:0] data);
        trend_result_t r;
        if (due_results.size() == 0)
        begin
            failures++;
            $display("%0t: result beat with none due, expected nothing, actual %0h",
                     $time, data);
            return;
        end
        r = due_results.pop_front();
        compare_field("trade_signal", 64'(r.sig), 64'(data[1:0]));
        compare_field("average_price", 64'(r.avg_price), 64'(data[33:2]));
        compare_field("average_volatility", 64'(r.avg_vol), 64'(data[57:34]));
        compare_field("price_deviation", 64'(r.deviation), 64'(data[89:58]));
        compare_field("padding", 64'd0, 64'(data[95:90]));
    endfunction

    function int pending();
        return due_results.size();
    endfunction

endclass

module ema_trend_signal_core_test;

    // Run length and pacing: the number of random ticks, the watchdog's cycle
    // limit, the settle time after a drain and the tail wait at the end.
    localparam int RANDOM_TICKS  = 536;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 60;

    // The block ignores a write to this index; it must leave every register alone.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // Receiver behavior over one stretch of cycles.
    localparam int RECV_STEADY  = 0;
    localparam int RECV_CHOPPY  = 1;
    localparam int RECV_BLOCKED = 2;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    // tick_price [31:0], tick_volatility [55:32]
    logic [ets_pkg::IN_DATA_W-1:0]      s_axis_tdata = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    // trade_signal [1:0], average_price [33:2], average_volatility [57:34],
    // price_deviation [89:58], zero [95:90]
    logic [ets_pkg::OUT_DATA_W-1:0]     m_axis_tdata;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [ets_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [ets_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

    trend_book    book;
    int           cycles;
    int           recv_mode;
    int           stretch_left;
    int           random_sent;
    logic [31:0]  walk_price = 32'h0064_0000;

    ema_trend_signal_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // The run is stopped here if the block hangs or stalls for far too long.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("ema_trend_signal_core verification failed");
            $finish;
        end
    end

    // Every handshake is sampled at the rising edge, where all stimulus has
    // settled from the previous edge. A configuration beat is mirrored first,
    // then a result beat is checked against the oldest tick still due, and
    // only then is a newly accepted tick added behind it. The block can
    // take the next tick in the same cycle that it hands out a result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                book.write_reg(cfg_index, cfg_data);
            if (m_axis_tvalid && m_axis_tready)
                book.check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                book.note_tick(s_axis_tdata[31:0], s_axis_tdata[55:32]);
        end
    end

    // The receiver alternates between stretches of steady acceptance, a
    // cycle-by-cycle coin toss, and outright blocking. Blocking stretches
    // can run long enough that a second result piles up inside the block.
    always @(posedge clk)
    begin
        if (stretch_left == 0)
        begin
            recv_mode = $urandom_range(RECV_STEADY, RECV_BLOCKED);
            stretch_left = (recv_mode == RECV_BLOCKED) ? $urandom_range(1, 90)
                                                       : $urandom_range(20, 300);
        end
        stretch_left--;
        case (recv_mode)
            RECV_STEADY: m_axis_tready <= 1'b1;
            RECV_CHOPPY: m_axis_tready <= ($urandom_range(0, 1) == 1);
            default:     m_axis_tready <= 1'b0;
        endcase
    end

    // Presents one tick beat and returns at the edge where it is taken.
    // The valid stays high so that the next call can follow back to back.
    task automatic send_tick(logic [31:0] price, logic [23:0] vol);
        s_axis_tdata  <= {vol, price};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic pause_ticks(int n);
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [1:0] index, logic [23:0] data);
        cfg_index <= index;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic close_config();
        cfg_valid <= 1'b0;
    endtask

    // Stops the tick stream and waits until every due result has come back.
    // Every tick yields a result, so the block is idle once the queue is empty.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random ticks in bursts. Most prices follow a random walk so that they
    // stay near the averages and the buy and sell decisions both come up;
    // the rest are jumps anywhere in the range and the two extremes.
    task automatic random_ticks(int count);
        int           left;
        int           burst;
        logic [31:0]  price;
        logic [23:0]  vol;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 12);
            if (burst > left)
                burst = left;
            repeat (burst)
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        price = $urandom;
                        walk_price = price;
                    end
                    1: price = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
                    default:
                    begin
                        walk_price = walk_price + $urandom_range(0, 4096) - 2048;
                        price = walk_price;
                    end
                endcase
                vol = ($urandom_range(0, 9) == 0) ? 24'($urandom_range(0, 24'hFF_FFFF))
                                                  : 24'($urandom_range(0, 60000));
                send_tick(price, vol);
            end
            left -= burst;
            random_sent += burst;
            // Roughly a third of the bursts run straight into the next one.
            if ($urandom_range(0, 2) != 0)
                pause_ticks($urandom_range(1, 60));
        end
    endtask

    // Picks a fresh setting for all three registers, leaning on the extremes.
    // Bits above a register's width carry random values; the block drops them.
    task automatic random_config();
        logic [15:0] alpha;
        logic [23:0] limit;
        logic [7:0]  warmup;
        case ($urandom_range(0, 4))
            0:       alpha = 16'd1;
            1:       alpha = 16'hFFFF;
            2:       alpha = 16'd0;
            default: alpha = 16'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0:       limit = 24'd0;
            1:       limit = 24'hFF_FFFF;
            default: limit = 24'($urandom_range(0, 60000));
        endcase
        case ($urandom_range(0, 3))
            0:       warmup = 8'd0;
            1:       warmup = 8'd255;
            default: warmup = 8'($urandom_range(0, 20));
        endcase
        write_reg(ets_pkg::REG_ALPHA, {8'($urandom), alpha});
        write_reg(ets_pkg::REG_LIMIT, limit);
        write_reg(ets_pkg::REG_WARMUP, {16'($urandom), warmup});
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNUSED, 24'($urandom));
        close_config();
    endtask

    initial
    begin
        logic [31:0] level;
        int          phase_len;

        book = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults after reset. The first tick loads the averages
        // with full-scale values, the next ones swing across the whole range.
        send_tick(32'hFFFF_FFFF, 24'hFF_FFFF);
        send_tick(32'h0000_0000, 24'h00_0000);
        send_tick(32'hFFFF_FFFF, 24'h00_0000);
        send_tick(32'h0000_0000, 24'hFF_FFFF);
        send_tick(32'h0001_8000, 24'h00_4CCD);
        random_ticks(150);

        // The sender holds off here until every result is back.
        drain_results();

        // A write to the unused index first, then the heaviest weight, the
        // widest limit and no warm-up at all.
        write_reg(REG_UNUSED, 24'hFF_FFFF);
        write_reg(ets_pkg::REG_ALPHA, {8'($urandom), 16'hFFFF});
        write_reg(ets_pkg::REG_LIMIT, 24'hFF_FFFF);
        write_reg(ets_pkg::REG_WARMUP, {16'($urandom), 8'd0});
        close_config();
        send_tick(32'h0000_0000, 24'h00_0000);
        send_tick(32'hFFFF_FFFF, 24'hFF_FFFF);
        send_tick(32'h1234_5678, 24'h00_1000);
        random_ticks(100);
        drain_results();

        // Zero weight freezes the averages, so a price can be aimed exactly at
        // the price average. With a zero limit a price above it must still hold.
        write_reg(ets_pkg::REG_ALPHA, {8'($urandom), 16'd0});
        write_reg(ets_pkg::REG_LIMIT, 24'd0);
        close_config();
        level = book.price_avg;
        send_tick(level, 24'h00_0100);
        send_tick(level + 32'd1, 24'h00_0100);
        send_tick(level - 32'd1, 24'h00_0100);
        drain_results();

        // Same frozen averages with the widest limit: above the average buys,
        // equal to it holds.
        write_reg(ets_pkg::REG_LIMIT, 24'hFF_FFFF);
        close_config();
        send_tick(level + 32'd1, 24'h00_0000);
        send_tick(level, 24'h00_0000);
        send_tick(level - 32'd1, 24'h00_0000);
        drain_results();

        // Random phases, each with its own register setting. Registers are
        // only written once the previous phase has fully drained.
        random_sent = 0;
        while (random_sent < RANDOM_TICKS)
        begin
            phase_len = $urandom_range(60, 140);
            if (phase_len > RANDOM_TICKS - random_sent)
                phase_len = RANDOM_TICKS - random_sent;
            random_config();
            random_ticks(phase_len);
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (book.failures == 0 && book.pending() == 0)
            $display("ema_trend_signal_core verification clean");
        else
            $display("ema_trend_signal_core verification failed");
        $finish;
    end

endmodule
